// ----- rtl/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

	localparam int KEY_W   = 32;
	localparam int TAG_W   = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_POP    = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t             op;
		logic [KEY_W-1:0]     key;
		logic [TAG_W-1:0]     tag;
	} cell_cmd_t;

	typedef struct packed {
		logic occupied;
		logic at_tail;
		logic at_end;
		logic prev_cond;
	} cell_pos_t;

endpackage
`default_nettype wire

// ----- rtl/sorted_priority_queue_core.sv -----
// insert, remove and clear: one result, registered in the cycle after the request is taken
// list: one result per held entry (one empty-status result if none held), one per cycle while out_ready is high
// a new request is taken every cycle while idle and the result slot is free or draining
// each insert, remove or list step updates the whole cell row at once: one key compare per cell
// reset: fill count, state and result slot cleared; entry storage is not reset
`default_nettype none
module sorted_priority_queue_core import spq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic signed [31:0] key,
	input  wire logic [31:0]        tag,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic                    entry_valid,
	output logic signed [31:0]      out_key,
	output logic [31:0]             out_tag,
	output logic [4:0]              count,
	output logic                    last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    remain_q;
	logic             out_valid_q;
	status_t          status_q;
	logic             entry_valid_q;
	logic [KEY_W-1:0] out_key_q;
	logic [TAG_W-1:0] out_tag_q;
	logic [COUNT_W-1:0] count_q;
	logic             last_q;

	logic             slot_free;
	logic             accept;
	op_t              op_in;
	cell_cmd_t        cmd;
	logic [KEY_W-1:0] head_key;
	logic [TAG_W-1:0] head_tag;
	logic [CW-1:0]    fill_d;
	logic [CW+COUNT_W-1:0] fill_ext;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign op_in     = op_t'(op);

	always_comb begin
		cmd.op  = CELL_HOLD;
		cmd.key = key;
		cmd.tag = tag;
		fill_d  = fill_q;
		if (accept) begin
			unique case (op_in)
				OP_INSERT: begin
					if (fill_q != FULL_CNT) begin
						cmd.op = CELL_INSERT;
						fill_d = fill_q + ONE_CNT;
					end
				end
				OP_REMOVE: begin
					if (fill_q != '0) begin
						cmd.op = CELL_POP;
						fill_d = fill_q - ONE_CNT;
					end
				end
				OP_CLEAR: begin
					fill_d = '0;
				end
				OP_LIST: begin
					if (fill_q != '0) begin
						cmd.op = CELL_ROTATE;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == S_LIST && slot_free) begin
			cmd.op = CELL_ROTATE;
		end
	end

	assign fill_ext = {{COUNT_W{1'b0}}, fill_d};

	spq_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk      (clk),
		.cmd      (cmd),
		.fill     (fill_q),
		.head_key (head_key),
		.head_tag (head_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			remain_q      <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_OK;
			entry_valid_q <= 1'b0;
			out_key_q     <= '0;
			out_tag_q     <= '0;
			count_q       <= '0;
			last_q        <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				out_valid_q   <= 1'b1;
				status_q      <= ST_OK;
				entry_valid_q <= 1'b0;
				out_key_q     <= '0;
				out_tag_q     <= '0;
				count_q       <= fill_ext[COUNT_W-1:0];
				last_q        <= 1'b1;
				unique case (op_in)
					OP_INSERT: begin
						if (fill_q == FULL_CNT) begin
							status_q <= ST_FULL;
						end
					end
					OP_REMOVE: begin
						if (fill_q == '0) begin
							status_q <= ST_EMPTY;
						end else begin
							entry_valid_q <= 1'b1;
							out_key_q     <= head_key;
							out_tag_q     <= head_tag;
						end
					end
					OP_CLEAR: begin
					end
					OP_LIST: begin
						if (fill_q == '0) begin
							status_q <= ST_EMPTY;
						end else begin
							entry_valid_q <= 1'b1;
							out_key_q     <= head_key;
							out_tag_q     <= head_tag;
							last_q        <= fill_q == ONE_CNT;
							if (fill_q != ONE_CNT) begin
								state_q  <= S_LIST;
								remain_q <= fill_q - ONE_CNT;
							end
						end
					end
					default: begin
					end
				endcase
			end else if (state_q == S_LIST && slot_free) begin
				out_valid_q   <= 1'b1;
				status_q      <= ST_OK;
				entry_valid_q <= 1'b1;
				out_key_q     <= head_key;
				out_tag_q     <= head_tag;
				count_q       <= fill_ext[COUNT_W-1:0];
				last_q        <= remain_q == ONE_CNT;
				remain_q      <= remain_q - ONE_CNT;
				if (remain_q == ONE_CNT) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_valid = entry_valid_q;
	assign out_key     = out_key_q;
	assign out_tag     = out_tag_q;
	assign count       = count_q;
	assign last        = last_q;

endmodule
`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none
module spq_cell import spq_pkg::*; #(
	parameter bit HEAD = 1'b0
) (
	input  wire logic             clk,
	input  wire cell_cmd_t        cmd,
	input  wire cell_pos_t        pos,
	input  wire logic [KEY_W-1:0] left_key,
	input  wire logic [TAG_W-1:0] left_tag,
	input  wire logic [KEY_W-1:0] right_key,
	input  wire logic [TAG_W-1:0] right_tag,
	input  wire logic [KEY_W-1:0] wrap_key,
	input  wire logic [TAG_W-1:0] wrap_tag,
	output logic      [KEY_W-1:0] key_q,
	output logic      [TAG_W-1:0] tag_q,
	output logic                  cond
);

	logic gt;
	logic ge;

	assign gt   = $signed(key_q) > $signed(cmd.key);
	assign ge   = $signed(key_q) >= $signed(cmd.key);
	assign cond = pos.occupied && (HEAD ? gt : ge);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_HOLD: begin
			end
			CELL_INSERT: begin
				if (pos.prev_cond) begin
					key_q <= left_key;
					tag_q <= left_tag;
				end else if (cond || pos.at_tail) begin
					key_q <= cmd.key;
					tag_q <= cmd.tag;
				end
			end
			CELL_POP: begin
				key_q <= right_key;
				tag_q <= right_tag;
			end
			CELL_ROTATE: begin
				if (pos.at_end) begin
					key_q <= wrap_key;
					tag_q <= wrap_tag;
				end else begin
					key_q <= right_key;
					tag_q <= right_tag;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/spq_chain.sv -----
`default_nettype none
module spq_chain import spq_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire cell_cmd_t        cmd,
	input  wire logic [CW-1:0]    fill,
	output logic      [KEY_W-1:0] head_key,
	output logic      [TAG_W-1:0] head_tag
);

	logic [KEY_W-1:0] keys  [DEPTH];
	logic [TAG_W-1:0] tags  [DEPTH];
	logic             conds [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_pos_t        pos;
		logic [KEY_W-1:0] lk;
		logic [TAG_W-1:0] lt;
		logic [KEY_W-1:0] rk;
		logic [TAG_W-1:0] rt;

		assign pos.occupied = fill > CW'(i);
		assign pos.at_tail  = fill == CW'(i);
		assign pos.at_end   = fill == CW'(i + 1);

		if (i == 0) begin : g_head
			assign pos.prev_cond = 1'b0;
			assign lk = cmd.key;
			assign lt = cmd.tag;
		end else begin : g_body
			assign pos.prev_cond = conds[i-1];
			assign lk = keys[i-1];
			assign lt = tags[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rk = keys[i];
			assign rt = tags[i];
		end else begin : g_mid
			assign rk = keys[i+1];
			assign rt = tags[i+1];
		end

		spq_cell #(
			.HEAD (i == 0)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.pos       (pos),
			.left_key  (lk),
			.left_tag  (lt),
			.right_key (rk),
			.right_tag (rt),
			.wrap_key  (keys[0]),
			.wrap_tag  (tags[0]),
			.key_q     (keys[i]),
			.tag_q     (tags[i]),
			.cond      (conds[i])
		);
	end

	assign head_key = keys[0];
	assign head_tag = tags[0];

endmodule
`default_nettype wire

// ----- rtl/spq_checker.sv -----
`default_nettype none
module spq_checker import spq_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [1:0]         op,
	input wire logic signed [31:0] key,
	input wire logic [31:0]        tag,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [1:0]         status,
	input wire logic               entry_valid,
	input wire logic signed [31:0] out_key,
	input wire logic [31:0]        out_tag,
	input wire logic [4:0]         count,
	input wire logic               last
);

	// stalled result holds valid, key, tag and last
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
			&& $stable(last))
		else $error("stalled result changed");

	a_entry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_valid |-> status == ST_OK)
		else $error("entry carried with error status");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_EMPTY) |-> !entry_valid && last)
		else $error("error result not single");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> count == 5'd0)
		else $error("empty status with nonzero count");

	// a list in progress blocks new requests
	a_list_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("request taken during list");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
`default_nettype wire
